[rtl/four_channel_dma_controller_unit_macros.svh]
// Assertion macros for the DMA controller checker
`ifndef FOUR_CHANNEL_DMA_CONTROLLER_UNIT_MACROS_SVH
`define FOUR_CHANNEL_DMA_CONTROLLER_UNIT_MACROS_SVH

// Implication checked on every clock, off during reset
`define DMA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset
`define DMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dma4_pkg.sv]
// Shared types and constants for the four-channel DMA controller
`default_nettype none
package dma4_pkg;
    localparam logic [2:0] MODE_REG   = 3'd0;
    localparam logic [2:0] MODE_TICK  = 3'd1;
    localparam logic [2:0] MODE_VBL   = 3'd2;
    localparam logic [2:0] MODE_HBL   = 3'd3;
    localparam logic [2:0] MODE_SND   = 3'd4;
    localparam logic [2:0] MODE_RDRET = 3'd5;

    localparam logic [1:0] SEL_SRC  = 2'd0;
    localparam logic [1:0] SEL_DST  = 2'd1;
    localparam logic [1:0] SEL_CTRL = 2'd2;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam int EN_B = 31;
    localparam int IRQ_B = 30;
    localparam int WIDE_B = 26;
    localparam int RPT_B = 25;

    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  channel;
        logic [1:0]  reg_select;
        logic [31:0] write_value;
        logic [31:0] read_data;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  op_channel;
        logic [31:0] bus_address;
        logic [31:0] bus_data;
        logic        wide;
        logic        irq;
        logic        last;
    } out_item_t;
endpackage
`default_nettype wire

[rtl/dma4_front.sv]
// Front end: accepts input transactions into a command queue
`default_nettype none
module dma4_front #(
    parameter int QDEPTH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire dma4_pkg::in_item_t in_item,
    output logic                    cmd_valid,
    input  wire logic               cmd_take,
    output dma4_pkg::in_item_t      cmd_item
);
    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    dma4_pkg::in_item_t q_mem [QDEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          do_push, do_pop;

    assign full      = (cnt_reg == (AW+1)'(QDEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;
    assign cmd_item  = q_mem[rp_reg];

    // Storage for queued transactions
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wp_reg] <= in_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= (wp_reg == AW'(QDEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_pop)
            begin
                rp_reg <= (rp_reg == AW'(QDEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end
endmodule
`default_nettype wire

[rtl/dma4_back.sv]
// Back end: channel state and a single sequencer that visits each channel and emits bus operations
`default_nettype none
module dma4_back #(
    parameter int NUM_CHANNELS = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_take,
    input  wire dma4_pkg::in_item_t cmd_item,
    output logic                    empty,
    input  wire logic               pop,
    output dma4_pkg::out_item_t     res
);
    localparam int CW = $clog2(NUM_CHANNELS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TICK = 2'd1;

    logic [27:0] src_base_reg [NUM_CHANNELS];
    logic [27:0] dst_base_reg [NUM_CHANNELS];
    logic [31:0] ctrl_reg     [NUM_CHANNELS];
    logic [31:0] cur_src_reg  [NUM_CHANNELS];
    logic [31:0] cur_dst_reg  [NUM_CHANNELS];
    logic [31:0] held_reg     [NUM_CHANNELS];
    logic [15:0] count_reg    [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] run_reg, rdone_reg, await_reg;

    logic [1:0]    state_reg;
    logic [CW-1:0] idx_reg;
    logic          any_reg;
    logic          ovalid_reg;
    dma4_pkg::out_item_t out_reg;

    // Output slot is free when empty or being drained
    logic slot_free;
    assign slot_free = !ovalid_reg || pop;
    assign empty = !ovalid_reg;
    assign res   = out_reg;

    // Every transaction, tick included, leaves the queue when the sequencer starts on it
    assign cmd_take = (state_reg == ST_IDLE) && cmd_valid && slot_free;

    // Per-channel view at current tick index
    logic [31:0] c;
    logic        wide_b, act, is_last_ch, fin;
    logic [31:0] sz;
    logic [15:0] cnt_after;
    assign c          = ctrl_reg[idx_reg];
    assign wide_b     = c[dma4_pkg::WIDE_B];
    assign sz         = wide_b ? 32'd4 : 32'd2;
    assign act        = run_reg[idx_reg] && !await_reg[idx_reg];
    assign is_last_ch = (idx_reg == CW'(NUM_CHANNELS-1));
    assign cnt_after  = rdone_reg[idx_reg] ? count_reg[idx_reg] - 16'd1 : count_reg[idx_reg];
    assign fin        = (cnt_after == 16'd0);

    // Is there an active channel above the current index
    logic later_act;
    always_comb
    begin
        later_act = 1'b0;
        for (int k = 0; k < NUM_CHANNELS; k++)
        begin
            if (k > int'(idx_reg) && run_reg[k] && !await_reg[k])
            begin
                later_act = 1'b1;
            end
        end
    end

    function automatic logic [31:0] step_addr(input logic [31:0] a, input logic [1:0] m,
                                              input logic [31:0] s, input logic up3);
        logic [31:0] r;
        r = a;
        if (m == 2'd0 || (m == 2'd3 && up3))
        begin
            r = a + s;
        end
        else if (m == 2'd1)
        begin
            r = a - s;
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            any_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
            out_reg    <= '0;
            run_reg    <= '0;
            rdone_reg  <= '0;
            await_reg  <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                src_base_reg[i] <= '0;
                dst_base_reg[i] <= '0;
                ctrl_reg[i]     <= '0;
                cur_src_reg[i]  <= '0;
                cur_dst_reg[i]  <= '0;
                held_reg[i]     <= '0;
                count_reg[i]    <= '0;
            end
        end
        else
        begin
            if (pop && ovalid_reg)
            begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid && slot_free)
                    begin
                        if (cmd_item.mode == dma4_pkg::MODE_TICK)
                        begin
                            state_reg <= ST_TICK;
                            idx_reg   <= '0;
                            any_reg   <= 1'b0;
                        end
                        else
                        begin
                            // Non-tick transactions give one empty result
                            ovalid_reg <= 1'b1;
                            out_reg    <= '0;
                            out_reg.last <= 1'b1;
                            if (cmd_item.mode == dma4_pkg::MODE_REG)
                            begin
                                if (cmd_item.reg_select == dma4_pkg::SEL_SRC)
                                begin
                                    src_base_reg[cmd_item.channel] <= (cmd_item.channel == 2'd3)
                                        ? cmd_item.write_value[27:0]
                                        : {1'b0, cmd_item.write_value[26:0]};
                                end
                                else if (cmd_item.reg_select == dma4_pkg::SEL_DST)
                                begin
                                    dst_base_reg[cmd_item.channel] <= (cmd_item.channel == 2'd3)
                                        ? cmd_item.write_value[27:0]
                                        : {1'b0, cmd_item.write_value[26:0]};
                                end
                                else if (cmd_item.reg_select == dma4_pkg::SEL_CTRL)
                                begin
                                    run_reg[cmd_item.channel] <=
                                        cmd_item.write_value[dma4_pkg::EN_B] &&
                                        !ctrl_reg[cmd_item.channel][dma4_pkg::EN_B];
                                    cur_src_reg[cmd_item.channel] <=
                                        {4'd0, src_base_reg[cmd_item.channel]};
                                    cur_dst_reg[cmd_item.channel] <=
                                        {4'd0, dst_base_reg[cmd_item.channel]};
                                    rdone_reg[cmd_item.channel] <= 1'b0;
                                    await_reg[cmd_item.channel] <= 1'b0;
                                    if (cmd_item.write_value[dma4_pkg::EN_B] &&
                                        !ctrl_reg[cmd_item.channel][dma4_pkg::EN_B])
                                    begin
                                        count_reg[cmd_item.channel] <= (cmd_item.channel == 2'd3)
                                            ? cmd_item.write_value[15:0]
                                            : {2'b00, cmd_item.write_value[13:0]};
                                    end
                                    else
                                    begin
                                        count_reg[cmd_item.channel] <= '0;
                                    end
                                    ctrl_reg[cmd_item.channel] <= cmd_item.write_value;
                                end
                            end
                            else if (cmd_item.mode == dma4_pkg::MODE_VBL ||
                                     cmd_item.mode == dma4_pkg::MODE_HBL ||
                                     cmd_item.mode == dma4_pkg::MODE_SND)
                            begin
                                for (int i = 0; i < NUM_CHANNELS; i++)
                                begin
                                    if (ctrl_reg[i][dma4_pkg::EN_B] && !run_reg[i] &&
                                        ((cmd_item.mode == dma4_pkg::MODE_VBL &&
                                          ctrl_reg[i][13:12] == 2'd1) ||
                                         (cmd_item.mode == dma4_pkg::MODE_HBL &&
                                          ctrl_reg[i][13:12] == 2'd2) ||
                                         (cmd_item.mode == dma4_pkg::MODE_SND &&
                                          ctrl_reg[i][13:12] == 2'd3 && (i == 1 || i == 2))))
                                    begin
                                        if (i == 3 || cmd_item.mode == dma4_pkg::MODE_SND)
                                        begin
                                            count_reg[i] <= ctrl_reg[i][15:0];
                                        end
                                        else
                                        begin
                                            count_reg[i] <= {1'b0, ctrl_reg[i][14:0]};
                                        end
                                        cur_src_reg[i] <= {4'd0, src_base_reg[i]};
                                        cur_dst_reg[i] <= {4'd0, dst_base_reg[i]};
                                        run_reg[i]     <= 1'b1;
                                        rdone_reg[i]   <= 1'b0;
                                        await_reg[i]   <= 1'b0;
                                    end
                                end
                            end
                            else if (cmd_item.mode == dma4_pkg::MODE_RDRET)
                            begin
                                if (await_reg[cmd_item.channel])
                                begin
                                    held_reg[cmd_item.channel]  <= cmd_item.read_data;
                                    rdone_reg[cmd_item.channel] <= 1'b1;
                                    await_reg[cmd_item.channel] <= 1'b0;
                                end
                            end
                        end
                    end
                end
                ST_TICK:
                begin
                    if (!act)
                    begin
                        // Skip idle channel; close out with an empty result if none issued
                        if (is_last_ch)
                        begin
                            if (!any_reg && slot_free)
                            begin
                                ovalid_reg   <= 1'b1;
                                out_reg      <= '0;
                                out_reg.last <= 1'b1;
                                state_reg    <= ST_IDLE;
                            end
                            else if (any_reg)
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                    else if (slot_free)
                    begin
                        ovalid_reg            <= 1'b1;
                        any_reg               <= 1'b1;
                        out_reg.op_channel    <= 2'(idx_reg);
                        out_reg.wide          <= wide_b;
                        out_reg.irq           <= fin && c[dma4_pkg::IRQ_B];
                        out_reg.last          <= !later_act;
                        if (rdone_reg[idx_reg])
                        begin
                            out_reg.kind        <= dma4_pkg::KIND_WRITE;
                            out_reg.bus_address <= cur_dst_reg[idx_reg];
                            out_reg.bus_data    <= wide_b ? held_reg[idx_reg]
                                                          : {16'd0, held_reg[idx_reg][15:0]};
                            cur_dst_reg[idx_reg] <= step_addr(cur_dst_reg[idx_reg], c[22:21],
                                                              sz, 1'b1);
                            rdone_reg[idx_reg]   <= 1'b0;
                            count_reg[idx_reg]   <= cnt_after;
                        end
                        else
                        begin
                            out_reg.kind        <= dma4_pkg::KIND_READ;
                            out_reg.bus_address <= cur_src_reg[idx_reg];
                            out_reg.bus_data    <= '0;
                            cur_src_reg[idx_reg] <= step_addr(cur_src_reg[idx_reg], c[24:23],
                                                              sz, 1'b0);
                            await_reg[idx_reg]   <= 1'b1;
                        end
                        if (fin)
                        begin
                            run_reg[idx_reg]   <= 1'b0;
                            await_reg[idx_reg] <= 1'b0;
                            if (!c[dma4_pkg::RPT_B])
                            begin
                                ctrl_reg[idx_reg][dma4_pkg::EN_B] <= 1'b0;
                            end
                            else
                            begin
                                count_reg[idx_reg] <= (idx_reg == CW'(3)) ? 16'hFFFF : 16'h7FFF;
                                cur_src_reg[idx_reg] <= {4'd0, src_base_reg[idx_reg]};
                                if (c[22:21] == 2'd3)
                                begin
                                    cur_dst_reg[idx_reg] <= {4'd0, dst_base_reg[idx_reg]};
                                end
                            end
                        end
                        if (is_last_ch || !later_act)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/four_channel_dma_controller_unit.sv]
// Top level of the four-channel DMA controller
// A non-tick result is registered into the output slot at the accepting edge.
// A tick sends the sequencer through the channels in order, one channel per cycle while the
// output slot is free; it registers one result per active channel, or an empty result if none.
// A new transaction is taken only when the sequencer is idle and the output slot is free.
// Reset: rst_n clears all channel registers, the command queue and the output slot.
`default_nettype none
module four_channel_dma_controller_unit #(
    parameter int NUM_CHANNELS = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire dma4_pkg::in_item_t  in_item,
    output logic                     empty,
    input  wire logic                pop,
    output dma4_pkg::out_item_t      out_item
);
    logic               cmd_valid, cmd_take;
    dma4_pkg::in_item_t cmd_item;

    dma4_front #(.QDEPTH(2)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd_item(cmd_item)
    );

    dma4_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
        .cmd_item(cmd_item), .empty(empty), .pop(pop), .res(out_item)
    );
endmodule
`default_nettype wire

[rtl/dma4_checker.sv]
// Port-level checker for the DMA controller, bound to the top level
`default_nettype none
`include "four_channel_dma_controller_unit_macros.svh"
module dma4_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                empty,
    input wire logic                pop,
    input wire dma4_pkg::out_item_t out_item
);
    `DMA_ASSERT_IMPL(a_kind_ok, clk, rst_n, !empty, out_item.kind != 2'd3, "bad kind")
    `DMA_ASSERT_IMPL(a_none_last, clk, rst_n, !empty && out_item.kind == dma4_pkg::KIND_NONE,
        out_item.last && !out_item.irq, "empty result not final")
    `DMA_ASSERT_IMPL(a_rd_zero, clk, rst_n, !empty && out_item.kind == dma4_pkg::KIND_READ,
        out_item.bus_data == 32'd0, "read carries data")
    `DMA_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_item),
        "result dropped")
endmodule

bind four_channel_dma_controller_unit dma4_checker u_chk (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .out_item(out_item)
);
`default_nettype wire

[test/four_channel_dma_controller_unit_test.sv]
// Self-checking testbench for the four-channel DMA controller
`timescale 1ns / 100ps
`default_nettype none
module four_channel_dma_controller_unit_test;

    // Channel state mirror and expected bus-operation queue
    class dma_scoreboard;
        logic [27:0] src_base [4];
        logic [27:0] dst_base [4];
        logic [31:0] ctrl [4];
        logic [31:0] cur_src [4];
        logic [31:0] cur_dst [4];
        logic [31:0] held [4];
        logic [15:0] count [4];
        bit running [4];
        bit have_data [4];
        bit waiting [4];
        dma4_pkg::out_item_t pending_ops [$];
        int errors;

        function void clear();
            for (int i = 0; i < 4; i++)
            begin
                src_base[i] = 0; dst_base[i] = 0; ctrl[i] = 0; cur_src[i] = 0;
                cur_dst[i] = 0; held[i] = 0; count[i] = 0; running[i] = 0;
                have_data[i] = 0; waiting[i] = 0;
            end
            errors = 0;
        endfunction

        function logic [31:0] step_addr(logic [31:0] a, logic [1:0] m, int sz, bit up3);
            if (m == 2'd0 || (m == 2'd3 && up3))
                return a + sz;
            if (m == 2'd1)
                return a - sz;
            return a;
        endfunction

        function void start_on(logic [1:0] timing, int first, int lst, logic [15:0] lo_mask);
            for (int i = first; i <= lst; i++)
            begin
                if (ctrl[i][dma4_pkg::EN_B] && !running[i] && ctrl[i][13:12] == timing)
                begin
                    count[i] = ctrl[i][15:0] & (i == 3 ? 16'hFFFF : lo_mask);
                    cur_dst[i] = {4'd0, dst_base[i]};
                    cur_src[i] = {4'd0, src_base[i]};
                    running[i] = 1; have_data[i] = 0; waiting[i] = 0;
                end
            end
        endfunction

        // Note an accepted input transaction and queue what it produces
        function void note_input(dma4_pkg::in_item_t t);
            dma4_pkg::out_item_t r;
            int n;
            logic [31:0] c;
            int sz;
            bit rise;
            n = 0;
            case (t.mode)
                dma4_pkg::MODE_REG:
                begin
                    if (t.reg_select == dma4_pkg::SEL_SRC)
                        src_base[t.channel] = t.write_value[27:0]
                            & (t.channel == 3 ? 28'hFFFFFFF : 28'h7FFFFFF);
                    else if (t.reg_select == dma4_pkg::SEL_DST)
                        dst_base[t.channel] = t.write_value[27:0]
                            & (t.channel == 3 ? 28'hFFFFFFF : 28'h7FFFFFF);
                    else if (t.reg_select == dma4_pkg::SEL_CTRL)
                    begin
                        rise = t.write_value[dma4_pkg::EN_B] && !ctrl[t.channel][dma4_pkg::EN_B];
                        running[t.channel] = rise;
                        cur_dst[t.channel] = {4'd0, dst_base[t.channel]};
                        cur_src[t.channel] = {4'd0, src_base[t.channel]};
                        have_data[t.channel] = 0; waiting[t.channel] = 0;
                        count[t.channel] = rise ? (t.write_value[15:0]
                            & (t.channel == 3 ? 16'hFFFF : 16'h3FFF)) : 16'h0;
                        ctrl[t.channel] = t.write_value;
                    end
                end
                dma4_pkg::MODE_TICK:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (!running[i] || waiting[i])
                            continue;
                        c = ctrl[i];
                        sz = c[dma4_pkg::WIDE_B] ? 4 : 2;
                        r = '0;
                        r.op_channel = 2'(i);
                        r.wide = c[dma4_pkg::WIDE_B];
                        if (have_data[i])
                        begin
                            r.kind = dma4_pkg::KIND_WRITE;
                            r.bus_address = cur_dst[i];
                            r.bus_data = c[dma4_pkg::WIDE_B] ? held[i] : {16'h0, held[i][15:0]};
                            cur_dst[i] = step_addr(cur_dst[i], c[22:21], sz, 1);
                            have_data[i] = 0;
                            count[i] = count[i] - 16'd1;
                        end
                        else
                        begin
                            r.kind = dma4_pkg::KIND_READ;
                            r.bus_address = cur_src[i];
                            cur_src[i] = step_addr(cur_src[i], c[24:23], sz, 0);
                            waiting[i] = 1;
                        end
                        if (count[i] == 0)
                        begin
                            running[i] = 0; waiting[i] = 0;
                            if (!c[dma4_pkg::RPT_B])
                                ctrl[i][dma4_pkg::EN_B] = 1'b0;
                            else
                            begin
                                count[i] = (i == 3) ? 16'hFFFF : 16'h7FFF;
                                cur_src[i] = {4'd0, src_base[i]};
                                if (c[22:21] == 2'd3)
                                    cur_dst[i] = {4'd0, dst_base[i]};
                            end
                            r.irq = c[dma4_pkg::IRQ_B];
                        end
                        pending_ops.push_back(r);
                        n++;
                    end
                end
                dma4_pkg::MODE_VBL: start_on(2'd1, 0, 3, 16'h7FFF);
                dma4_pkg::MODE_HBL: start_on(2'd2, 0, 3, 16'h7FFF);
                dma4_pkg::MODE_SND: start_on(2'd3, 1, 2, 16'hFFFF);
                dma4_pkg::MODE_RDRET:
                begin
                    if (waiting[t.channel])
                    begin
                        held[t.channel] = t.read_data;
                        have_data[t.channel] = 1;
                        waiting[t.channel] = 0;
                    end
                end
                default: ;
            endcase
            if (n == 0)
            begin
                r = '0;
                pending_ops.push_back(r);
            end
            r = pending_ops.pop_back();
            r.last = 1;
            pending_ops.push_back(r);
        endfunction

        // Compare one accepted result against the oldest expectation
        function void check_result(dma4_pkg::out_item_t got);
            dma4_pkg::out_item_t e;
            if (pending_ops.size() == 0)
            begin
                $error("unexpected result transaction %h", got);
                errors++;
                return;
            end
            e = pending_ops.pop_front();
            if (got.kind !== e.kind)
            begin
                $error("kind: expected %0d, got %0d", e.kind, got.kind); errors++;
            end
            if (got.op_channel !== e.op_channel)
            begin
                $error("op_channel: expected %0d, got %0d", e.op_channel, got.op_channel);
                errors++;
            end
            if (got.bus_address !== e.bus_address)
            begin
                $error("bus_address: expected %h, got %h", e.bus_address, got.bus_address);
                errors++;
            end
            if (got.bus_data !== e.bus_data)
            begin
                $error("bus_data: expected %h, got %h", e.bus_data, got.bus_data);
                errors++;
            end
            if (got.wide !== e.wide)
            begin
                $error("wide: expected %0d, got %0d", e.wide, got.wide); errors++;
            end
            if (got.irq !== e.irq)
            begin
                $error("irq: expected %0d, got %0d", e.irq, got.irq); errors++;
            end
            if (got.last !== e.last)
            begin
                $error("last: expected %0d, got %0d", e.last, got.last); errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    dma4_pkg::in_item_t in_item;
    logic empty;
    logic pop;
    dma4_pkg::out_item_t out_item;

    int send_idle_pct;
    int recv_idle_pct;
    bit recv_hold;
    bit hold_go;
    int cycle_count;
    int sent;
    dma_scoreboard dma_sb;

    four_channel_dma_controller_unit u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
        .empty(empty), .pop(pop), .out_item(out_item)
    );

    // Clock
    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Timeout
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver: random pop, checked at each accepting edge
    initial
    begin
        pop = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                dma_sb.check_result(out_item);
            pop <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver stall, counted in cycles, while the sender keeps offering
    initial
    begin
        recv_hold = 0;
        wait (hold_go);
        repeat (5) @(posedge clk);
        recv_hold <= 1;
        repeat (300) @(posedge clk);
        recv_hold <= 0;
    end

    // Offer one input transaction until accepted; push stays high for the caller
    task automatic send_item(dma4_pkg::in_item_t t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 0;
            @(posedge clk);
        end
        push <= 1;
        in_item <= t;
        @(posedge clk);
        while (full)
            @(posedge clk);
        dma_sb.note_input(t);
        sent++;
    endtask

    task automatic send_fields(logic [2:0] m, logic [1:0] ch, logic [1:0] sel,
                               logic [31:0] wv, logic [31:0] rd);
        dma4_pkg::in_item_t t;
        t.mode = m; t.channel = ch; t.reg_select = sel;
        t.write_value = wv; t.read_data = rd;
        send_item(t);
    endtask

    // Pause input until every expected result has come
    task automatic drain();
        push <= 0;
        @(posedge clk);
        while (dma_sb.pending_ops.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Tick, answering each read request the controller raises except at random about one in ten
    task automatic tick_and_serve();
        logic [3:0] read_chs;
        send_fields(dma4_pkg::MODE_TICK, 0, 0, $urandom, $urandom);
        read_chs = 0;
        for (int i = 0; i < 4; i++)
            if (dma_sb.waiting[i])
                read_chs[i] = 1;
        for (int i = 0; i < 4; i++)
            if (read_chs[i] && $urandom_range(9) != 0)
                send_fields(dma4_pkg::MODE_RDRET, 2'(i), 2'($urandom_range(3)),
                            $urandom, $urandom);
    endtask

    // One well-formed transfer setup with random content
    task automatic random_setup();
        logic [1:0] ch;
        logic [31:0] c;
        logic [2:0] trig;
        ch = 2'($urandom_range(3));
        send_fields(dma4_pkg::MODE_REG, ch, dma4_pkg::SEL_SRC, $urandom, $urandom);
        send_fields(dma4_pkg::MODE_REG, ch, dma4_pkg::SEL_DST, $urandom, $urandom);
        c = $urandom;
        c[15:0] = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(4));
        if ($urandom_range(3) != 0)
            c[dma4_pkg::EN_B] = 1;
        if ($urandom_range(1))
            send_fields(dma4_pkg::MODE_REG, ch, dma4_pkg::SEL_CTRL, 32'h0, $urandom);
        send_fields(dma4_pkg::MODE_REG, ch, dma4_pkg::SEL_CTRL, c, $urandom);
        trig = 3'(dma4_pkg::MODE_VBL + $urandom_range(2));
        if ($urandom_range(1))
            send_fields(trig, 2'($urandom_range(3)), 2'($urandom_range(3)), $urandom, $urandom);
    endtask

    initial
    begin
        dma_sb = new();
        dma_sb.clear();
        push = 0;
        in_item = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go = 0;
        sent = 0;
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: register extremes, each trigger, zero count, repeat, wide/narrow
        send_fields(dma4_pkg::MODE_REG, 3, dma4_pkg::SEL_SRC, 32'hFFFFFFFF, 32'h0);
        send_fields(dma4_pkg::MODE_REG, 0, dma4_pkg::SEL_DST, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_fields(dma4_pkg::MODE_REG, 3, dma4_pkg::SEL_DST, 32'h0, 32'h0);
        send_fields(dma4_pkg::MODE_REG, 2, 2'd3, 32'hFFFFFFFF, 32'h0);
        send_fields(dma4_pkg::MODE_REG, 3, dma4_pkg::SEL_CTRL, 32'hC4000002, 32'h0);
        tick_and_serve();
        tick_and_serve();
        tick_and_serve();
        tick_and_serve();
        send_fields(dma4_pkg::MODE_REG, 0, dma4_pkg::SEL_CTRL, 32'h80000000, 32'h0);
        tick_and_serve();
        send_fields(dma4_pkg::MODE_RDRET, 0, 0, 32'h0, 32'hFFFFFFFF);
        send_fields(dma4_pkg::MODE_REG, 1, dma4_pkg::SEL_CTRL, 32'hC3E03001, 32'h0);
        send_fields(dma4_pkg::MODE_SND, 0, 0, 32'h0, 32'h0);
        tick_and_serve();
        tick_and_serve();
        send_fields(dma4_pkg::MODE_REG, 2, dma4_pkg::SEL_CTRL, 32'h82601001, 32'h0);
        send_fields(dma4_pkg::MODE_VBL, 0, 0, 32'h0, 32'h0);
        tick_and_serve();
        tick_and_serve();
        send_fields(dma4_pkg::MODE_HBL, 0, 0, 32'h0, 32'h0);
        send_fields(3'd6, 0, 0, 32'h0, 32'h0);
        send_fields(3'd7, 3, 3, 32'hFFFFFFFF, 32'hFFFFFFFF);
        drain();

        // Random phases with varying idle rates
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 62 : 0;
            recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 25 : 0;
            if (phase == 2)
                hold_go = 1;
            while (sent < (phase + 1) * 136)
            begin
                case ($urandom_range(9))
                    0: random_setup();
                    1: send_fields(3'($urandom_range(7)), 2'($urandom), 2'($urandom),
                                   $urandom, $urandom);
                    2: send_fields(3'(dma4_pkg::MODE_VBL + $urandom_range(2)),
                                   2'($urandom_range(3)), 2'($urandom_range(3)),
                                   $urandom, $urandom);
                    default: tick_and_serve();
                endcase
            end
            drain();
        end

        // Finish once the pipeline is quiet, reporting whether every expectation was met
        drain();
        repeat (20) @(posedge clk);
        if (dma_sb.errors == 0 && dma_sb.pending_ops.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
